### hdl/tbs_pkg.sv
// Shared constants, status codes and controller command type for the
// token bucket packet shaper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 16;
	localparam int NEED_W      = 16;
	localparam int LEVEL_W     = 16;
	localparam int STATUS_W    = 3;
	localparam int QCOUNT_W    = 7;
	localparam int ENTRY_W     = ID_W + NEED_W;

	localparam logic [LEVEL_W-1:0] DEPTH_RESET = LEVEL_W'(10);

	localparam logic ACT_TOKEN  = 1'b0;
	localparam logic ACT_PACKET = 1'b1;

	localparam logic [STATUS_W-1:0] ST_TOKEN_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOKEN_DROPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL    = 3'd4;

	typedef struct packed {
		logic take_event;
		logic finish;
		logic cfg_write;
	} tbs_cmd_t;

endpackage

`default_nettype wire

### hdl/tbs_evt_if.sv
// Event input channel: valid/ready plus action, packet id and need.
// Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbs_evt_if;
	import tbs_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [ID_W-1:0]   packet_id;
	logic [NEED_W-1:0] tokens_needed;

	modport source (output valid, action, packet_id, tokens_needed, input ready);
	modport sink   (input valid, action, packet_id, tokens_needed, output ready);
endinterface

`default_nettype wire

### hdl/tbs_res_if.sv
// Result output channel: valid/ready plus status, level and release fields.
// Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbs_res_if;
	import tbs_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LEVEL_W-1:0]  bucket_level;
	logic                released;
	logic [ID_W-1:0]     released_id;
	logic [QCOUNT_W-1:0] queue_count;

	modport source (output valid, status, bucket_level, released, released_id,
		queue_count, input ready);
	modport sink   (input valid, status, bucket_level, released, released_id,
		queue_count, output ready);
endinterface

`default_nettype wire

### hdl/tbs_cfg_if.sv
// Configuration write channel: valid/ready plus bucket depth write data.
// Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbs_cfg_if;
	import tbs_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hdl/tbs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/tbs_ctrl.sv
// Controller state machine: event handshake, head read wait, result load.
// Depends on tbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             evt_valid,
	output logic                  evt_ready,
	output logic                  res_valid,
	input  wire logic             res_ready,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	output tbs_pkg::tbs_cmd_t     cmd
);
	import tbs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   res_free;

	assign res_free  = !res_valid_q || res_ready;
	assign evt_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.take_event = (state_q == S_IDLE) && evt_valid;
		cmd.finish     = (state_q == S_CHECK) && res_free;
		cmd.cfg_write  = cfg_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_CHECK) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/tbs_dp.sv
// Datapath: bucket level, depth register, FIFO pointers and count, queue RAM,
// release check and result registers. Depends on tbs_pkg and tbs_ram.
`timescale 1ns / 1ps
`default_nettype none

module tbs_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tbs_pkg::tbs_cmd_t            cmd,
	input  wire logic                         action,
	input  wire logic [tbs_pkg::ID_W-1:0]     packet_id,
	input  wire logic [tbs_pkg::NEED_W-1:0]   tokens_needed,
	input  wire logic [tbs_pkg::LEVEL_W-1:0]  cfg_data,
	output logic      [tbs_pkg::STATUS_W-1:0] status,
	output logic      [tbs_pkg::LEVEL_W-1:0]  bucket_level,
	output logic                              released,
	output logic      [tbs_pkg::ID_W-1:0]     released_id,
	output logic      [tbs_pkg::QCOUNT_W-1:0] queue_count
);
	import tbs_pkg::*;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [LEVEL_W-1:0]  depth_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [STATUS_W-1:0] evt_status_q;

	logic [STATUS_W-1:0] evt_status;
	logic                do_add;
	logic                do_push;
	logic [ENTRY_W-1:0]  head_entry;
	logic [NEED_W-1:0]   head_need;
	logic [ID_W-1:0]     head_id;
	logic                do_release;

	tbs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (tail_q),
		.wdata ({packet_id, tokens_needed}),
		.raddr (head_q),
		.rdata (head_entry)
	);

	assign head_id   = head_entry[ENTRY_W-1:NEED_W];
	assign head_need = head_entry[NEED_W-1:0];

	always_comb begin
		do_add  = 1'b0;
		do_push = 1'b0;
		if (action == ACT_TOKEN) begin
			if (level_q >= depth_q) begin
				evt_status = ST_TOKEN_DROPPED;
			end else begin
				evt_status = ST_TOKEN_ADDED;
				do_add     = cmd.take_event;
			end
		end else if (tokens_needed > depth_q) begin
			evt_status = ST_TOO_LARGE;
		end else if (count_q >= CNT_FULL) begin
			evt_status = ST_QUEUE_FULL;
		end else begin
			evt_status = ST_QUEUED;
			do_push    = cmd.take_event;
		end
	end

	assign do_release = cmd.finish && (count_q != '0) && (head_need <= level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
			level_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.cfg_write) begin
				depth_q <= cfg_data;
			end
			if (do_add) begin
				level_q <= level_q + 1'b1;
			end
			if (do_push) begin
				tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (do_release) begin
				level_q <= level_q - head_need;
				head_q  <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_event) begin
			evt_status_q <= evt_status;
		end
		if (cmd.finish) begin
			status      <= evt_status_q;
			released    <= do_release;
			if (do_release) begin
				bucket_level <= level_q - head_need;
				released_id  <= head_id;
				queue_count  <= QCOUNT_W'(count_q - 1'b1);
			end else begin
				bucket_level <= level_q;
				released_id  <= '0;
				queue_count  <= QCOUNT_W'(count_q);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/token_bucket_packet_shaper_top.sv
// Top level of the token bucket packet shaper: controller, datapath and
// channel hookup. Depends on tbs_pkg, the channel interfaces, tbs_ctrl, tbs_dp.
//
// Usage:
//   evt carries one event per beat: a token tick (action 0) or a packet
//   arrival (action 1) with its id and token need. res returns exactly one
//   result beat per event: status, bucket level, release flag and id, and
//   the number of packets still waiting. cfg writes the bucket depth; write
//   it only while no event is in flight. cfg is always ready.
//   Each event steps through the controller states S_IDLE, S_READ and S_CHECK;
//   its result is registered on leaving S_CHECK, after the registered read of
//   the queue head from the queue RAM that follows each event's update. A new
//   event is accepted only in S_IDLE, once the last one has left S_CHECK.
//   The next event is taken while a result still waits on res; if res
//   stalls, the following result is held back until the waiting beat leaves.
//   Reset empties the queue, clears the bucket and sets the depth to 10.
//   Queue RAM contents are not cleared; only written entries are read.
`timescale 1ns / 1ps
`default_nettype none

module token_bucket_packet_shaper_top (
	input wire logic clk,
	input wire logic arst_n,
	tbs_evt_if.sink  evt,
	tbs_res_if.source res,
	tbs_cfg_if.sink  cfg
);
	import tbs_pkg::*;

	tbs_cmd_t cmd;

	tbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cmd       (cmd)
	);

	tbs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (evt.action),
		.packet_id     (evt.packet_id),
		.tokens_needed (evt.tokens_needed),
		.cfg_data      (cfg.data),
		.status        (res.status),
		.bucket_level  (res.bucket_level),
		.released      (res.released),
		.released_id   (res.released_id),
		.queue_count   (res.queue_count)
	);

endmodule

`default_nettype wire

### tb/shaper_sb_pkg.sv
// Scoreboard for the token bucket packet shaper: bucket and wait-queue predictor
// plus the queue of outcomes still owed by the block. Depends on tbs_pkg.
`timescale 1ns / 1ps

package shaper_sb_pkg;
	import tbs_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEVEL_W-1:0]  bucket_level;
		logic                released;
		logic [ID_W-1:0]     released_id;
		logic [QCOUNT_W-1:0] queue_count;
	} shaper_outcome_t;

	class shaper_scoreboard;
		logic [LEVEL_W-1:0] depth;
		logic [LEVEL_W-1:0] level;
		logic [ID_W-1:0]    id_slot [QUEUE_DEPTH];
		logic [NEED_W-1:0]  need_slot [QUEUE_DEPTH];
		int unsigned        head_idx;
		int unsigned        tail_idx;
		int unsigned        waiting;
		shaper_outcome_t    outcome_q [$];
		int unsigned        errors;
		int unsigned        events;
		int unsigned        releases;
		int unsigned        token_drops;
		int unsigned        oversize_drops;
		int unsigned        full_drops;
		int unsigned        peak_waiting;

		function new();
			depth = DEPTH_RESET;
			level = '0;
			head_idx = 0;
			tail_idx = 0;
			waiting = 0;
			errors = 0;
			events = 0;
			releases = 0;
			token_drops = 0;
			oversize_drops = 0;
			full_drops = 0;
			peak_waiting = 0;
		endfunction

		function void set_depth(logic [LEVEL_W-1:0] value);
			depth = value;
		endfunction

		// Advance the bucket and queue by one accepted event beat and
		// record the outcome the block owes for it.
		function void note_event(logic action, logic [ID_W-1:0] id,
			logic [NEED_W-1:0] need);
			shaper_outcome_t o;
			o = '0;
			if (action == ACT_TOKEN) begin
				if (level >= depth) begin
					o.status = ST_TOKEN_DROPPED;
					token_drops++;
				end else begin
					level = level + 1'b1;
					o.status = ST_TOKEN_ADDED;
				end
			end else if (need > depth) begin
				o.status = ST_TOO_LARGE;
				oversize_drops++;
			end else if (waiting >= QUEUE_DEPTH) begin
				o.status = ST_QUEUE_FULL;
				full_drops++;
			end else begin
				id_slot[tail_idx] = id;
				need_slot[tail_idx] = need;
				tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
				waiting++;
				o.status = ST_QUEUED;
			end
			if (waiting > peak_waiting)
				peak_waiting = waiting;
			if (waiting != 0 && need_slot[head_idx] <= level) begin
				level = level - need_slot[head_idx];
				o.released = 1'b1;
				o.released_id = id_slot[head_idx];
				head_idx = (head_idx + 1) % QUEUE_DEPTH;
				waiting--;
				releases++;
			end
			o.bucket_level = level;
			o.queue_count = QCOUNT_W'(waiting);
			events++;
			outcome_q.push_back(o);
		endfunction

		function void compare_field(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			end
		endfunction

		function void check_result(shaper_outcome_t got);
			shaper_outcome_t want;
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing outstanding, expected none, actual status %0d",
					$time, got.status);
				return;
			end
			want = outcome_q.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("bucket_level", want.bucket_level, got.bucket_level);
			compare_field("released", want.released, got.released);
			compare_field("released_id", want.released_id, got.released_id);
			compare_field("queue_count", want.queue_count, got.queue_count);
		endfunction
	endclass

endpackage

### tb/tb_top.sv
// Top of the token bucket packet shaper testbench: clock, reset, event and
// config drivers, result sink and watchdog. Depends on tbs_pkg, the channel
// interfaces, shaper_sb_pkg and token_bucket_packet_shaper_top.
`timescale 1ns / 1ps

module tb_top;
	import tbs_pkg::*;
	import shaper_sb_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;
	int   stall_cycles;

	shaper_scoreboard sb;
	shaper_outcome_t  got_beat;

	tbs_evt_if evt_bus ();
	tbs_res_if res_bus ();
	tbs_cfg_if cfg_bus ();

	token_bucket_packet_shaper_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	always #5 clk = ~clk;

	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_bus.ready = steady || ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready) begin
			got_beat.status = res_bus.status;
			got_beat.bucket_level = res_bus.bucket_level;
			got_beat.released = res_bus.released;
			got_beat.released_id = res_bus.released_id;
			got_beat.queue_count = res_bus.queue_count;
			sb.check_result(got_beat);
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("** token_bucket_packet_shaper_top: FAILED **");
		$finish;
	end

	// Entered and left at a falling edge; valid stays high for the next beat.
	task automatic send_event(input logic action, input logic [ID_W-1:0] id,
		input logic [NEED_W-1:0] need);
		while (!steady && $urandom_range(99) < 16) begin
			evt_bus.valid = 1'b0;
			@(negedge clk);
		end
		evt_bus.valid = 1'b1;
		evt_bus.action = action;
		evt_bus.packet_id = id;
		evt_bus.tokens_needed = need;
		do @(posedge clk); while (!evt_bus.ready);
		sb.note_event(action, id, need);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_event(ACT_TOKEN, ID_W'($urandom), NEED_W'($urandom));
	endtask

	task automatic wait_drained();
		evt_bus.valid = 1'b0;
		while (sb.outcome_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_depth(input logic [LEVEL_W-1:0] value);
		cfg_bus.valid = 1'b1;
		cfg_bus.data = value;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.set_depth(value);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic run_phase(input int depth_val, input int count, input int tick_pct,
		input int max_need, input int pause_at);
		int need_cap;
		int r;
		logic [NEED_W-1:0] need;
		wait_drained();
		write_depth(LEVEL_W'(depth_val));
		need_cap = (max_need < depth_val) ? max_need : depth_val;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained();
			if ($urandom_range(99) < tick_pct) begin
				send_tick();
			end else begin
				r = $urandom_range(99);
				if (r < 10)
					need = '0;
				else if (r < 80)
					need = NEED_W'($urandom_range(need_cap, 0));
				else if (r < 90)
					need = NEED_W'((depth_val <= 64) ? depth_val : max_need);
				else if (depth_val < 65535)
					need = NEED_W'($urandom_range(65535, depth_val + 1));
				else
					need = NEED_W'($urandom_range(need_cap, 0));
				send_event(ACT_PACKET, ID_W'($urandom), need);
			end
		end
	endtask

	// Block the head behind a packet the bucket cannot yet pay for, overflow the
	// queue, then drain it with ticks; no idling on either side here.
	task automatic fill_queue();
		int depth_val;
		wait_drained();
		depth_val = sb.level + 6;
		if (depth_val > 65535)
			depth_val = 65535;
		write_depth(LEVEL_W'(depth_val));
		steady = 1'b1;
		send_event(ACT_PACKET, ID_W'($urandom), NEED_W'(depth_val));
		repeat (70) send_event(ACT_PACKET, ID_W'($urandom), NEED_W'($urandom_range(2, 0)));
		repeat (100) send_tick();
		steady = 1'b0;
	endtask

	initial begin
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		evt_bus.valid = 1'b0;
		evt_bus.action = ACT_TOKEN;
		evt_bus.packet_id = '0;
		evt_bus.tokens_needed = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_event(ACT_TOKEN, 16'hFFFF, 16'hFFFF);
		send_event(ACT_PACKET, 16'hFFFF, 16'hFFFF);
		send_event(ACT_PACKET, 16'h0000, 16'h0000);
		send_event(ACT_PACKET, 16'h1234, 16'd10);
		send_event(ACT_PACKET, 16'hABCD, 16'h0000);
		send_event(ACT_PACKET, 16'h5A5A, 16'd11);
		repeat (9) send_tick();
		repeat (3) send_tick();

		run_phase(1, 50, 70, 1, -1);
		run_phase(3, 60, 70, 3, 30);
		run_phase(0, 20, 40, 0, -1);
		fill_queue();
		run_phase(40, 70, 85, 6, -1);
		run_phase(5, 50, 75, 4, -1);
		run_phase(65535, 60, 60, 8, -1);

		wait_drained();
		repeat (8) @(negedge clk);
		if (sb.outcome_q.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d results never arrived", $time, sb.outcome_q.size());
		end
		$display("Covered %0d events over depths 0 to 65535: %0d releases, %0d tokens dropped,",
			sb.events, sb.releases, sb.token_drops);
		$display("%0d oversize and %0d queue-full drops, peak queue %0d, %0d errors",
			sb.oversize_drops, sb.full_drops, sb.peak_waiting, sb.errors);
		if (sb.errors == 0)
			$display("** token_bucket_packet_shaper_top: PASSED **");
		else
			$display("** token_bucket_packet_shaper_top: FAILED **");
		$finish;
	end

endmodule
